>>> sv/pvt_pkg.sv
// Shared types and constants for the perspective vertex transform.
`default_nettype none

package pvt_pkg;

    localparam int CLIP_W    = 47;  // clip components, clamped to -2^46 .. 2^46 - 1
    localparam int REM_W     = 48;  // divider partial remainder
    localparam int QUO_W     = 33;  // quotient magnitude bits produced
    localparam int NDC_W     = 32;  // normalized coordinates, Q16.16
    localparam int DIV_STEPS = 33;  // one quotient bit per stage
    localparam int LANES     = 3;   // x, y, z share one clip w
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_MVP_ROW0   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MVP_ROW1   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MVP_ROW2   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MVP_ROW3   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_VPORT_ROWX = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_VPORT_ROWY = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_ZOOM       = 3'd6;

    typedef logic [63:0] row_t;

    typedef struct packed {
        logic valid;
        logic sat;
    } ctrl_t;

    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [QUO_W-1:0] num;
        logic [QUO_W-1:0] quo;
        logic             ovf;
        logic             neg;
    } lane_t;

    typedef struct packed {
        ctrl_t                  ctrl;
        logic                   fault;
        logic [CLIP_W-1:0]      den;
        lane_t [LANES-1:0]      lane;
    } div_stage_t;

endpackage

`default_nettype wire

>>> sv/pvt_mvp.sv
// Offset add and 4x4 matrix multiply: point in, clip vector out (3 stages).
`default_nettype none

module pvt_mvp #(
    parameter int COORD_WIDTH = 16
) (
    input  wire                                        clk,
    input  wire                                        rst_n,
    input  wire                                        in_valid,
    input  wire logic signed [COORD_WIDTH-1:0]         point_x,
    input  wire logic signed [COORD_WIDTH-1:0]         point_y,
    input  wire logic signed [COORD_WIDTH-1:0]         point_z,
    input  wire logic signed [15:0]                    zoom,
    input  wire logic [3:0][63:0]                      rows,
    output pvt_pkg::ctrl_t                             clip_ctrl,
    output logic [3:0][pvt_pkg::CLIP_W-1:0]            clip
);

    localparam int AW   = ((COORD_WIDTH > 16) ? COORD_WIDTH : 16) + 1;
    localparam int PW   = COORD_WIDTH + 16;
    localparam int SUMW = PW + 2;
    localparam int CMW  = (SUMW > 48) ? SUMW : 48;

    localparam logic signed [AW-1:0] POS_MAX = AW'((64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1);
    localparam logic signed [AW-1:0] POS_MIN = AW'(-(64'sd1 <<< (COORD_WIDTH - 1)));
    localparam logic signed [CMW-1:0] CLIP_MAX = CMW'(64'sd70368744177663);
    localparam logic signed [CMW-1:0] CLIP_MIN = CMW'(-64'sd70368744177664);

    // stage 1: offset x
    logic signed [AW-1:0]          xsum;
    logic signed [COORD_WIDTH-1:0] px_next;
    logic                          sat1_next;
    logic                          sat3_next;
    logic signed [COORD_WIDTH-1:0] px_reg, py_reg, pz_reg;
    pvt_pkg::ctrl_t                c1_reg, c2_reg, c3_reg;

    assign xsum = AW'(point_x) + AW'(zoom);

    always_comb
    begin
        sat1_next = 1'b0;
        px_next   = COORD_WIDTH'(xsum);
        if (xsum > POS_MAX)
        begin
            px_next   = COORD_WIDTH'(POS_MAX);
            sat1_next = 1'b1;
        end
        else if (xsum < POS_MIN)
        begin
            px_next   = COORD_WIDTH'(POS_MIN);
            sat1_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c1_reg <= '0;
            c2_reg <= '0;
            c3_reg <= '0;
        end
        else
        begin
            c1_reg <= '{valid: in_valid, sat: sat1_next};
            c2_reg <= c1_reg;
            c3_reg <= '{valid: c2_reg.valid, sat: c2_reg.sat | sat3_next};
        end
    end

    always_ff @(posedge clk)
    begin
        px_reg <= px_next;
        py_reg <= point_y;
        pz_reg <= point_z;
    end

    // stage 2: sixteen products; w is the constant 1.0 (256 in Q8.8)
    logic signed [PW-1:0] prod_reg [4][4];

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 4; i++)
        begin
            prod_reg[i][0] <= $signed(rows[i][15:0])  * px_reg;
            prod_reg[i][1] <= $signed(rows[i][31:16]) * py_reg;
            prod_reg[i][2] <= $signed(rows[i][47:32]) * pz_reg;
            prod_reg[i][3] <= PW'($signed(rows[i][63:48])) <<< 8;
        end
    end

    // stage 3: row sums and clamp
    logic signed [CMW-1:0]            sum [4];
    logic [3:0][pvt_pkg::CLIP_W-1:0]  clip_next;
    logic [3:0][pvt_pkg::CLIP_W-1:0]  clip_reg;

    always_comb
    begin
        sat3_next = 1'b0;
        for (int i = 0; i < 4; i++)
        begin
            sum[i] = CMW'(prod_reg[i][0]) + CMW'(prod_reg[i][1])
                   + CMW'(prod_reg[i][2]) + CMW'(prod_reg[i][3]);
            clip_next[i] = pvt_pkg::CLIP_W'(sum[i]);
            if (sum[i] > CLIP_MAX)
            begin
                clip_next[i] = pvt_pkg::CLIP_W'(CLIP_MAX);
                sat3_next    = 1'b1;
            end
            else if (sum[i] < CLIP_MIN)
            begin
                clip_next[i] = pvt_pkg::CLIP_W'(CLIP_MIN);
                sat3_next    = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        clip_reg <= clip_next;
    end

    assign clip_ctrl = c3_reg;
    assign clip      = clip_reg;

endmodule

`default_nettype wire

>>> sv/pvt_div.sv
// Perspective divide: three restoring dividers sharing clip w, one quotient bit per stage.
`default_nettype none

module pvt_div (
    input  wire                                        clk,
    input  wire                                        rst_n,
    input  wire pvt_pkg::ctrl_t                        in_ctrl,
    input  wire logic [3:0][pvt_pkg::CLIP_W-1:0]       clip,
    output pvt_pkg::ctrl_t                             out_ctrl,
    output logic                                       out_fault,
    output logic [2:0][pvt_pkg::NDC_W-1:0]             ndc
);

    localparam int CW  = pvt_pkg::CLIP_W;
    localparam int RW  = pvt_pkg::REM_W;
    localparam int QW  = pvt_pkg::QUO_W;
    localparam int NW  = pvt_pkg::NDC_W;
    localparam int NS  = pvt_pkg::DIV_STEPS;

    localparam logic [QW-1:0] Q_POS_LIM = QW'(64'd2147483647);
    localparam logic [QW-1:0] Q_NEG_LIM = QW'(64'd2147483648);
    localparam logic [NW-1:0] NDC_MAX   = {1'b0, {(NW-1){1'b1}}};
    localparam logic [NW-1:0] NDC_MIN   = {1'b1, {(NW-1){1'b0}}};

    function automatic pvt_pkg::div_stage_t div_step(pvt_pkg::div_stage_t a);
        pvt_pkg::div_stage_t b;
        logic [RW-1:0]       r;
        b = a;
        for (int l = 0; l < pvt_pkg::LANES; l++)
        begin
            r = {a.lane[l].rem[RW-2:0], a.lane[l].num[QW-1]};
            b.lane[l].num = {a.lane[l].num[QW-2:0], 1'b0};
            if (r >= RW'(a.den))
            begin
                b.lane[l].rem = r - RW'(a.den);
                b.lane[l].quo = {a.lane[l].quo[QW-2:0], 1'b1};
            end
            else
            begin
                b.lane[l].rem = r;
                b.lane[l].quo = {a.lane[l].quo[QW-2:0], 1'b0};
            end
        end
        return b;
    endfunction

    // prep: magnitudes, sign, overflow precheck (|n| >= |d| * 2^17)
    pvt_pkg::div_stage_t prep;
    logic [CW-1:0]       nmag [3];

    always_comb
    begin
        prep.ctrl  = in_ctrl;
        prep.fault = (clip[3] == '0);
        prep.den   = clip[3][CW-1] ? (~clip[3] + 1'b1) : clip[3];
        for (int l = 0; l < pvt_pkg::LANES; l++)
        begin
            nmag[l] = clip[l][CW-1] ? (~clip[l] + 1'b1) : clip[l];
            prep.lane[l].rem = RW'(nmag[l] >> 17);
            prep.lane[l].num = {nmag[l][16:0], 16'b0};
            prep.lane[l].quo = '0;
            prep.lane[l].ovf = (nmag[l] >> 17) >= prep.den;
            prep.lane[l].neg = clip[l][CW-1] ^ clip[3][CW-1];
        end
    end

    pvt_pkg::div_stage_t st_reg [NS+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            st_reg[0].ctrl <= '0;
        else
            st_reg[0] <= prep;
    end

    for (genvar s = 1; s <= NS; s++)
    begin : g_step
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                st_reg[s].ctrl <= '0;
            else
                st_reg[s] <= div_step(st_reg[s-1]);
        end
    end

    // final: sign and saturate to Q16.16
    pvt_pkg::div_stage_t           last;
    logic [2:0][NW-1:0]            ndc_next;
    logic                          sat_any;
    logic [QW-1:0]                 q;
    pvt_pkg::ctrl_t                oc_reg;
    logic                          fault_reg;
    logic [2:0][NW-1:0]            ndc_reg;

    assign last = st_reg[NS];

    always_comb
    begin
        sat_any = 1'b0;
        q       = '0;
        for (int l = 0; l < pvt_pkg::LANES; l++)
        begin
            q = last.lane[l].quo;
            if (last.lane[l].neg)
            begin
                if (last.lane[l].ovf || q > Q_NEG_LIM)
                begin
                    ndc_next[l] = NDC_MIN;
                    sat_any     = 1'b1;
                end
                else
                    ndc_next[l] = NW'({QW{1'b0}} - q);
            end
            else
            begin
                if (last.lane[l].ovf || q > Q_POS_LIM)
                begin
                    ndc_next[l] = NDC_MAX;
                    sat_any     = 1'b1;
                end
                else
                    ndc_next[l] = NW'(q);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            oc_reg <= '0;
        else
            oc_reg <= '{valid: last.ctrl.valid,
                        sat:   last.ctrl.sat | (sat_any & ~last.fault)};
    end

    always_ff @(posedge clk)
    begin
        fault_reg <= last.fault;
        ndc_reg   <= ndc_next;
    end

    assign out_ctrl  = oc_reg;
    assign out_fault = fault_reg;
    assign ndc       = ndc_reg;

endmodule

`default_nettype wire

>>> sv/pvt_vport.sv
// Viewport rows applied to the normalized point, rounding and output registers.
`default_nettype none

module pvt_vport #(
    parameter int SCREEN_WIDTH = 24
) (
    input  wire                                        clk,
    input  wire                                        rst_n,
    input  wire pvt_pkg::ctrl_t                        in_ctrl,
    input  wire                                        in_fault,
    input  wire logic [2:0][pvt_pkg::NDC_W-1:0]        ndc,
    input  wire logic [1:0][63:0]                      vrows,
    output logic                                       done,
    output logic signed [SCREEN_WIDTH-1:0]             screen_x,
    output logic signed [SCREEN_WIDTH-1:0]             screen_y,
    output logic                                       divide_fault,
    output logic                                       saturated
);

    localparam int PW   = 16 + pvt_pkg::NDC_W;
    localparam int SUMW = PW + 2;
    localparam int RNDW = SUMW - 16;

    localparam logic signed [RNDW-1:0] S_MAX = RNDW'((64'sd1 <<< (SCREEN_WIDTH - 1)) - 64'sd1);
    localparam logic signed [RNDW-1:0] S_MIN = RNDW'(-(64'sd1 <<< (SCREEN_WIDTH - 1)));

    // stage A: products; fourth component is 1.0 in Q16.16
    logic signed [PW-1:0] prod_reg [2][4];
    pvt_pkg::ctrl_t       ca_reg, cb_reg;
    logic                 fa_reg, fb_reg;

    always_ff @(posedge clk)
    begin
        for (int r = 0; r < 2; r++)
        begin
            for (int j = 0; j < 3; j++)
                prod_reg[r][j] <= $signed(vrows[r][16*j +: 16]) * $signed(ndc[j]);
            prod_reg[r][3] <= PW'($signed(vrows[r][63:48])) <<< 16;
        end
        fa_reg <= in_fault;
        fb_reg <= fa_reg;
    end

    // stage B: sum, add half an LSB of Q.4, floor
    logic signed [SUMW-1:0] sum [2];
    logic signed [RNDW-1:0] rnd_reg [2];

    always_comb
    begin
        for (int r = 0; r < 2; r++)
            sum[r] = SUMW'(prod_reg[r][0]) + SUMW'(prod_reg[r][1])
                   + SUMW'(prod_reg[r][2]) + SUMW'(prod_reg[r][3])
                   + SUMW'(32768);
    end

    always_ff @(posedge clk)
    begin
        for (int r = 0; r < 2; r++)
            rnd_reg[r] <= sum[r][SUMW-1:16];
    end

    // stage C: clamp to screen width; zero coordinates on a divide fault
    logic signed [SCREEN_WIDTH-1:0] scr_next [2];
    logic                           sat_c;

    always_comb
    begin
        sat_c = 1'b0;
        for (int r = 0; r < 2; r++)
        begin
            scr_next[r] = SCREEN_WIDTH'(rnd_reg[r]);
            if (rnd_reg[r] > S_MAX)
            begin
                scr_next[r] = SCREEN_WIDTH'(S_MAX);
                sat_c       = 1'b1;
            end
            else if (rnd_reg[r] < S_MIN)
            begin
                scr_next[r] = SCREEN_WIDTH'(S_MIN);
                sat_c       = 1'b1;
            end
            if (fb_reg)
                scr_next[r] = '0;
        end
    end

    logic                           done_reg;
    logic signed [SCREEN_WIDTH-1:0] sx_reg, sy_reg;
    logic                           fault_reg, sat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ca_reg   <= '0;
            cb_reg   <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            ca_reg   <= in_ctrl;
            cb_reg   <= ca_reg;
            done_reg <= cb_reg.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        sx_reg    <= scr_next[0];
        sy_reg    <= scr_next[1];
        fault_reg <= fb_reg;
        sat_reg   <= cb_reg.sat | (sat_c & ~fb_reg);
    end

    assign done         = done_reg;
    assign screen_x     = sx_reg;
    assign screen_y     = sy_reg;
    assign divide_fault = fault_reg;
    assign saturated    = sat_reg;

endmodule

`default_nettype wire

>>> sv/perspective_vertex_transform.sv
// Top level: configuration registers and the three pipeline sections.
//
// Usage:
//   Points enter on start with point_x/y/z (signed Q8.8). busy is always low,
//   so a point is taken on every cycle that start is high.
//   Each point gives one result: done is high for one cycle
//   with screen_x/y (signed Q20.4), divide_fault and saturated.
//   Throughput is one point per cycle. The pipeline is the perspective
//   divide's 33 stages, one quotient bit per stage, plus 8 stages of offset,
//   matrix multiply, normalize, viewport and rounding.
//   The result has no backpressure; the receiver must take it when done is high.
//   Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready
//   is always high. Index 0-3 MVP rows, 4-5 viewport rows, 6 zoom offset.
//   Write configuration only while no point is in flight.
//   Reset clears all in-flight points; the MVP matrix resets to identity,
//   viewport rows and zoom offset to zero.
`default_nettype none

module perspective_vertex_transform #(
    parameter int COORD_WIDTH  = 16,
    parameter int SCREEN_WIDTH = 24
) (
    input  wire                                        clk,
    input  wire                                        rst_n,
    input  wire                                        start,
    output logic                                       busy,
    input  wire logic signed [COORD_WIDTH-1:0]         point_x,
    input  wire logic signed [COORD_WIDTH-1:0]         point_y,
    input  wire logic signed [COORD_WIDTH-1:0]         point_z,
    output logic                                       done,
    output logic signed [SCREEN_WIDTH-1:0]             screen_x,
    output logic signed [SCREEN_WIDTH-1:0]             screen_y,
    output logic                                       divide_fault,
    output logic                                       saturated,
    input  wire                                        cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic [pvt_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  wire logic [63:0]                           cfg_data
);

    localparam int LATENCY = 41;

    logic [3:0][63:0]  mvp_reg;
    logic [1:0][63:0]  vport_reg;
    logic signed [15:0] zoom_reg;
    logic              cfg_wr;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mvp_reg[0] <= 64'd256;
            mvp_reg[1] <= 64'd16777216;
            mvp_reg[2] <= 64'd1099511627776;
            mvp_reg[3] <= 64'd72057594037927936;
            vport_reg  <= '0;
            zoom_reg   <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_index)
                pvt_pkg::CFG_MVP_ROW0:   mvp_reg[0]   <= cfg_data;
                pvt_pkg::CFG_MVP_ROW1:   mvp_reg[1]   <= cfg_data;
                pvt_pkg::CFG_MVP_ROW2:   mvp_reg[2]   <= cfg_data;
                pvt_pkg::CFG_MVP_ROW3:   mvp_reg[3]   <= cfg_data;
                pvt_pkg::CFG_VPORT_ROWX: vport_reg[0] <= cfg_data;
                pvt_pkg::CFG_VPORT_ROWY: vport_reg[1] <= cfg_data;
                pvt_pkg::CFG_ZOOM:       zoom_reg     <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    pvt_pkg::ctrl_t                    clip_ctrl;
    logic [3:0][pvt_pkg::CLIP_W-1:0]   clip;
    pvt_pkg::ctrl_t                    ndc_ctrl;
    logic                              ndc_fault;
    logic [2:0][pvt_pkg::NDC_W-1:0]    ndc;

    pvt_mvp #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_mvp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start && !busy),
        .point_x   (point_x),
        .point_y   (point_y),
        .point_z   (point_z),
        .zoom      (zoom_reg),
        .rows      (mvp_reg),
        .clip_ctrl (clip_ctrl),
        .clip      (clip)
    );

    pvt_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ctrl   (clip_ctrl),
        .clip      (clip),
        .out_ctrl  (ndc_ctrl),
        .out_fault (ndc_fault),
        .ndc       (ndc)
    );

    pvt_vport #(
        .SCREEN_WIDTH (SCREEN_WIDTH)
    ) u_vport (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_ctrl      (ndc_ctrl),
        .in_fault     (ndc_fault),
        .ndc          (ndc),
        .vrows        (vport_reg),
        .done         (done),
        .screen_x     (screen_x),
        .screen_y     (screen_y),
        .divide_fault (divide_fault),
        .saturated    (saturated)
    );

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("accepted point did not produce a result on time");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LATENCY))
        else $error("result without a matching accepted point");

    a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && divide_fault) |-> (screen_x == '0 && screen_y == '0))
        else $error("divide fault with nonzero coordinates");

endmodule

`default_nettype wire

>>> verif/perspective_vertex_transform_tb.sv
// Self-checking testbench for the perspective vertex transform pipeline.
`default_nettype none

module perspective_vertex_transform_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CW = 16;
    localparam int SW = 24;
    localparam int LATENCY = 41;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int RANDOM_POINTS = 530;

    typedef struct packed {
        logic signed [SW-1:0] sx;
        logic signed [SW-1:0] sy;
        logic                 fault;
        logic                 sat;
    } screen_t;

    typedef struct {
        logic signed [CW-1:0] px;
        logic signed [CW-1:0] py;
        logic signed [CW-1:0] pz;
        bit                   typed;
        screen_t              want;
    } point_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic signed [CW-1:0] point_x = '0, point_y = '0, point_z = '0;
    logic done;
    logic signed [SW-1:0] screen_x, screen_y;
    logic divide_fault, saturated;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [pvt_pkg::CFG_IDX_W-1:0] cfg_index = pvt_pkg::CFG_MVP_ROW0;
    logic [63:0] cfg_data = '0;

    pvt_pkg::row_t mvp [4];
    pvt_pkg::row_t vport_x, vport_y;
    logic signed [15:0] zoom;

    screen_t screen_q[$];
    int errors = 0;
    int points_sent = 0;
    int results_seen = 0;
    int faults_seen = 0;
    int sats_seen = 0;
    int idle_cycles = 0;

    perspective_vertex_transform i_dut (
        .clk, .rst_n, .start, .busy, .point_x, .point_y, .point_z, .done,
        .screen_x, .screen_y, .divide_fault, .saturated,
        .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
    );

    always #5 clk = ~clk;

    function automatic longint clampv(longint v, longint lim, ref bit flag);
        if (v > lim) begin
            flag = 1;
            return lim;
        end
        if (v < -lim - 1) begin
            flag = 1;
            return -lim - 1;
        end
        return v;
    endfunction

    function automatic longint coef_of(pvt_pkg::row_t r, int j);
        logic signed [15:0] c;
        c = r[16*j +: 16];
        return longint'(c);
    endfunction

    function automatic longint floor16(longint v);
        return v >>> 16;
    endfunction

    function automatic screen_t transform_point(logic signed [CW-1:0] px,
                                                logic signed [CW-1:0] py,
                                                logic signed [CW-1:0] pz);
        bit flag;
        longint pos [4];
        longint clip [4];
        longint ndc [4];
        longint acc, ax, ay;
        screen_t r;
        flag = 0;
        r = '0;
        pos[0] = clampv(longint'(px) + longint'(zoom), 32767, flag);
        pos[1] = longint'(py);
        pos[2] = longint'(pz);
        pos[3] = 256;
        for (int i = 0; i < 4; i++) begin
            acc = 0;
            for (int j = 0; j < 4; j++) acc += coef_of(mvp[i], j) * pos[j];
            clip[i] = clampv(acc, 64'sd70368744177663, flag);
        end
        if (clip[3] == 0) begin
            r.fault = 1'b1;
        end else begin
            for (int i = 0; i < 3; i++)
                ndc[i] = clampv((clip[i] * 65536) / clip[3], 64'sd2147483647, flag);
            ndc[3] = 65536;
            ax = 0;
            ay = 0;
            for (int j = 0; j < 4; j++) begin
                ax += coef_of(vport_x, j) * ndc[j];
                ay += coef_of(vport_y, j) * ndc[j];
            end
            r.sx = SW'(clampv(floor16(ax + 32768), 64'sd8388607, flag));
            r.sy = SW'(clampv(floor16(ay + 32768), 64'sd8388607, flag));
        end
        r.sat = flag;
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch at result %0d: %s got %0d expected %0d",
                 results_seen, what, got, want);
        errors++;
    endtask

    // result checker: done is a one-cycle strobe, no backpressure
    always @(posedge clk) begin
        if (rst_n && done) begin
            screen_t w;
            if (screen_q.size() == 0) begin
                report_mismatch("unexpected done", 1, 0);
            end else begin
                w = screen_q.pop_front();
                if (screen_x !== w.sx) report_mismatch("screen_x", screen_x, w.sx);
                if (screen_y !== w.sy) report_mismatch("screen_y", screen_y, w.sy);
                if (divide_fault !== w.fault)
                    report_mismatch("divide_fault", divide_fault, w.fault);
                if (saturated !== w.sat) report_mismatch("saturated", saturated, w.sat);
                faults_seen += w.fault;
                sats_seen += w.sat;
            end
            results_seen++;
        end
    end

    always @(posedge clk) begin
        if ((start && !busy) || done || (cfg_valid && cfg_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired with %0d results pending", screen_q.size());
            $display("perspective_vertex_transform_tb failed");
            $finish;
        end
    end

    task automatic write_reg(logic [pvt_pkg::CFG_IDX_W-1:0] idx, pvt_pkg::row_t value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            pvt_pkg::CFG_MVP_ROW0:   mvp[0] = value;
            pvt_pkg::CFG_MVP_ROW1:   mvp[1] = value;
            pvt_pkg::CFG_MVP_ROW2:   mvp[2] = value;
            pvt_pkg::CFG_MVP_ROW3:   mvp[3] = value;
            pvt_pkg::CFG_VPORT_ROWX: vport_x = value;
            pvt_pkg::CFG_VPORT_ROWY: vport_y = value;
            pvt_pkg::CFG_ZOOM:       zoom = value[15:0];
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        while (screen_q.size() != 0) @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    // one transfer; optional random gap before it
    task automatic send_point(logic signed [CW-1:0] px, logic signed [CW-1:0] py,
                              logic signed [CW-1:0] pz, bit gaps);
        int gap;
        if (gaps) begin
            gap = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 60)
                                                : $urandom_range(0, 2);
            if (gap != 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        start   <= 1'b1;
        point_x <= px;
        point_y <= py;
        point_z <= pz;
        do @(posedge clk); while (busy);
        screen_q.push_back(transform_point(px, py, pz));
        points_sent++;
    endtask

    function automatic logic [15:0] rand_coef(int mode);
        case (mode)
            0: return 16'($urandom);
            1: return 16'($signed($urandom_range(0, 1023)) - 512);
            default: return ($urandom_range(0, 3) == 0) ? 16'h0000 : 16'($urandom);
        endcase
    endfunction

    function automatic pvt_pkg::row_t rand_row(int mode);
        pvt_pkg::row_t r;
        for (int j = 0; j < 4; j++) r[16*j +: 16] = rand_coef(mode);
        return r;
    endfunction

    function automatic logic [CW-1:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'($signed($urandom_range(0, 2047)) - 1024);
            default: return 16'($urandom);
        endcase
    endfunction

    point_row_t dir_rows[$];
    logic [CW-1:0] rx, ry, rz;
    screen_t got_want;

    initial begin
        // reset state: identity MVP, zero viewport and zoom -> screen is all zero
        mvp[0] = 64'd256; mvp[1] = 64'd16777216;
        mvp[2] = 64'd1099511627776; mvp[3] = 64'd72057594037927936;
        vport_x = '0; vport_y = '0; zoom = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        dir_rows = '{
            '{16'sh0000, 16'sh0000, 16'sh0000, 1, '{0, 0, 0, 0}},
            '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1, '{0, 0, 0, 0}},
            '{16'sh8000, 16'sh8000, 16'sh8000, 1, '{0, 0, 0, 0}},
            '{16'sh0100, -16'sh0100, 16'sh0080, 1, '{0, 0, 0, 0}}
        };
        foreach (dir_rows[k]) begin
            send_point(dir_rows[k].px, dir_rows[k].py, dir_rows[k].pz, 0);
            got_want = transform_point(dir_rows[k].px, dir_rows[k].py, dir_rows[k].pz);
            if (dir_rows[k].typed && got_want != dir_rows[k].want)
                report_mismatch("table row", k, 0);
        end
        start <= 1'b0;
        wait_drained();

        // simple viewport, zoom at max: saturation of offset x, normal divide
        write_reg(pvt_pkg::CFG_VPORT_ROWX, {16'sh0100, 16'sh0, 16'sh0, 16'sh0140});
        write_reg(pvt_pkg::CFG_VPORT_ROWY, {16'shFF00, 16'sh0, 16'sh0F00, 16'sh0});
        write_reg(pvt_pkg::CFG_ZOOM, 64'h7FFF);
        dir_rows = '{
            '{16'sh7FFF, 16'sh0100, 16'sh0, 0, '0},
            '{16'sh8000, 16'sh8000, 16'sh0, 0, '0},
            '{16'sh0000, 16'sh7FFF, 16'sh0, 0, '0},
            '{-16'sh0001, 16'sh0001, 16'sh0, 0, '0}
        };
        foreach (dir_rows[k]) send_point(dir_rows[k].px, dir_rows[k].py, dir_rows[k].pz, 0);
        start <= 1'b0;
        wait_drained();

        // zero clip w: w row all zero gives a fault and zeroed coordinates
        write_reg(pvt_pkg::CFG_ZOOM, 64'h8000);
        write_reg(pvt_pkg::CFG_MVP_ROW3, 64'd0);
        dir_rows = '{
            '{16'sh1234, 16'sh0, 16'sh0, 1, '{0, 0, 1, 0}},
            '{16'sh8000, 16'sh0, 16'sh0, 1, '{0, 0, 1, 1}}
        };
        foreach (dir_rows[k]) begin
            send_point(dir_rows[k].px, dir_rows[k].py, dir_rows[k].pz, 0);
            got_want = transform_point(dir_rows[k].px, dir_rows[k].py, dir_rows[k].pz);
            if (got_want != dir_rows[k].want) report_mismatch("table row", k, 0);
        end
        start <= 1'b0;
        wait_drained();

        // extreme matrices: tiny w against big x/y/z drives divide and screen clamps
        write_reg(pvt_pkg::CFG_ZOOM, 64'h0);
        write_reg(pvt_pkg::CFG_MVP_ROW0, {4{16'h7FFF}});
        write_reg(pvt_pkg::CFG_MVP_ROW1, {4{16'h8000}});
        write_reg(pvt_pkg::CFG_MVP_ROW2, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(pvt_pkg::CFG_MVP_ROW3, 64'h0001_0000_0000_0000);
        write_reg(pvt_pkg::CFG_VPORT_ROWX, {4{16'h7FFF}});
        write_reg(pvt_pkg::CFG_VPORT_ROWY, {4{16'h8000}});
        for (int k = 0; k < 8; k++) begin
            rx = rand_coord(); ry = rand_coord(); rz = rand_coord();
            send_point(rx, ry, rz, 0);
        end
        start <= 1'b0;
        wait_drained();

        // random phases, each with a fresh configuration
        for (int phase = 0; phase < 10; phase++) begin
            int mode;
            mode = phase % 3;
            write_reg(pvt_pkg::CFG_MVP_ROW0, rand_row(mode));
            write_reg(pvt_pkg::CFG_MVP_ROW1, rand_row(mode));
            write_reg(pvt_pkg::CFG_MVP_ROW2, rand_row(mode));
            // w row sometimes dominated by the constant term to keep divides sane
            write_reg(pvt_pkg::CFG_MVP_ROW3,
                      (phase % 4 == 1) ? 64'h0100_0000_0000_0000 | rand_row(1)
                                       : rand_row(mode));
            write_reg(pvt_pkg::CFG_VPORT_ROWX, rand_row(mode));
            write_reg(pvt_pkg::CFG_VPORT_ROWY, rand_row(mode));
            write_reg(pvt_pkg::CFG_ZOOM, 64'(rand_coef(mode)));
            for (int k = 0; k < RANDOM_POINTS / 10; k++) begin
                rx = rand_coord(); ry = rand_coord(); rz = rand_coord();
                send_point(rx, ry, rz, phase % 5 != 0);
            end
            start <= 1'b0;
            wait_drained();
        end

        $display("sent %0d points, checked %0d results (%0d divide faults, %0d clamped)",
                 points_sent, results_seen, faults_seen, sats_seen);
        $display("covered reset, extreme, zero-w and 10 random configuration phases");
        if (errors == 0 && screen_q.size() == 0)
            $display("perspective_vertex_transform_tb passed");
        else
            $display("perspective_vertex_transform_tb failed");
        $finish;
    end
endmodule

`default_nettype wire
